// ===== hw/rtl/svcsc_pkg.sv =====
// Shared types, widths and constants for the SVC susceptance controller.
// Used by the serial multiplier, the serial divider and the top level.
// Depends on nothing.
package svcsc_pkg;

   localparam int VOLT_BITS  = 24;
   localparam int FRAC_BITS  = 16;
   localparam int B_BITS     = FRAC_BITS + 3;
   localparam int CFG_V_BITS = 23;
   localparam int GAIN_BITS  = 16;
   localparam int GAIN_FRAC  = 8;
   localparam int TC_BITS    = 24;
   localparam int DT_BITS    = 16;
   localparam int TIMER_BITS = 23;

   localparam int TM2_BITS  = TC_BITS + 1;
   localparam int X_BITS    = VOLT_BITS + 2;
   localparam int DIFF_BITS = ((VOLT_BITS > CFG_V_BITS) ? VOLT_BITS : CFG_V_BITS) + 1;
   localparam int CMP_BITS  = DIFF_BITS + 9;
   localparam int PCT_BITS  = B_BITS + 8;

   localparam int MUL_A_MIN  = (TM2_BITS > DT_BITS + GAIN_BITS) ? TM2_BITS
                                                                 : DT_BITS + GAIN_BITS;
   localparam int MUL_A_BITS = (X_BITS - 1 > MUL_A_MIN) ? X_BITS - 1 : MUL_A_MIN;
   localparam int MUL_B_BITS = (TM2_BITS > B_BITS + 1) ? TM2_BITS : B_BITS + 1;
   localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;
   localparam int DIV_N_BITS = MUL_P_BITS + 1;
   localparam int DIV_D_BITS = TM2_BITS + 1 + GAIN_FRAC;

   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = (B_BITS > TC_BITS) ? B_BITS : TC_BITS;

   localparam logic [CSR_IDX_BITS-1:0] CSR_REF_VOLTAGE     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NOMINAL_VOLTAGE = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_B_UPPER         = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_B_LOWER         = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CTRL_GAIN       = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CTRL_TIME_CONST = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MEAS_TIME_CONST = 3'd6;

   localparam int CHG_PCT  = 100;
   localparam int PU_SCALE = 100;
   localparam int OV_PCT [3] = '{140, 125, 115};

   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
   localparam logic [TIMER_BITS-1:0] TRIP_LIMIT [3] =
      '{TIMER_BITS'(100000), TIMER_BITS'(1000000), TIMER_BITS'(5000000)};

   localparam logic signed [VOLT_BITS-1:0] VOLT_MAX = {1'b0, {(VOLT_BITS-1){1'b1}}};
   localparam logic signed [VOLT_BITS-1:0] VOLT_MIN = {1'b1, {(VOLT_BITS-1){1'b0}}};
   localparam logic signed [B_BITS-1:0]    SUSC_MAX = {1'b0, {(B_BITS-1){1'b1}}};
   localparam logic signed [B_BITS-1:0]    SUSC_MIN = {1'b1, {(B_BITS-1){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DEVP,
      ST_VMUL,
      ST_VDIV,
      ST_DEV,
      ST_GAIN,
      ST_T1,
      ST_T2,
      ST_BDIV,
      ST_UPDATE,
      ST_WRITE
   } state_type;

   // Signed saturation of a quotient magnitude with a separate sign.
   function automatic logic signed [VOLT_BITS-1:0] sat_volt(
      input logic [DIV_N_BITS-1:0] q, input logic neg);
      logic [DIV_N_BITS-1:0] lim;
      lim = DIV_N_BITS'(1) << (VOLT_BITS - 1);
      if (q >= lim) begin
         sat_volt = neg ? VOLT_MIN : VOLT_MAX;
      end else begin
         sat_volt = neg ? -$signed(q[VOLT_BITS-1:0]) : $signed(q[VOLT_BITS-1:0]);
      end
   endfunction

   function automatic logic signed [B_BITS-1:0] sat_susc(
      input logic [DIV_N_BITS-1:0] q, input logic neg);
      logic [DIV_N_BITS-1:0] lim;
      lim = DIV_N_BITS'(1) << (B_BITS - 1);
      if (q >= lim) begin
         sat_susc = neg ? SUSC_MIN : SUSC_MAX;
      end else begin
         sat_susc = neg ? -$signed(q[B_BITS-1:0]) : $signed(q[B_BITS-1:0]);
      end
   endfunction

endpackage

// ===== hw/rtl/svc_susceptance_controller_core.sv =====
// Top level of the SVC susceptance controller: sequencer, state and registers.
// Depends on svcsc_pkg, svcsc_mul and svcsc_div.
//
// Usage: one control step is offered on the req_ channel (voltage sample,
// elapsed microseconds, enable). A transfer happens when req_valid is high
// and req_stall is low. The block holds req_stall high while it works on a
// step, then returns exactly one result on the rsp_ channel, which transfers
// when rsp_valid is high and rsp_stall is low.
// An enabled step runs four multiplies and four divides on one bit-serial
// multiplier and one bit-serial divider, plus an update and a write state;
// a disabled or tripped step only runs the deviation divide. The result
// sits in an output register so the next step can be taken while the receiver
// stalls; a second result waits in the final state until that register frees up.
// Configuration writes on the csr_ channel are always ready and should only be
// made while no step is in flight.
// Reset (synchronous, active high) returns the configuration and controller
// state registers to their defaults, opens both switches, clears the
// protection timers and the trip latch, and empties the output register.
module svc_susceptance_controller_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [svcsc_pkg::VOLT_BITS-1:0]   req_voltage_sample,
   input  logic [svcsc_pkg::DT_BITS-1:0]            req_step_time,
   input  logic                                     req_enabled,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [svcsc_pkg::B_BITS-1:0]      rsp_susceptance,
   output logic signed [svcsc_pkg::VOLT_BITS-1:0]   rsp_measured_voltage,
   output logic signed [svcsc_pkg::B_BITS-1:0]      rsp_voltage_deviation,
   output logic                                     rsp_inductor_closed,
   output logic                                     rsp_capacitor_closed,
   output logic                                     rsp_value_changed,
   output logic                                     rsp_tripped,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [svcsc_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [svcsc_pkg::CSR_DATA_BITS-1:0]      csr_data
);
   import svcsc_pkg::*;

   // Configuration registers.
   logic [CFG_V_BITS-1:0]     ref_ff;
   logic [CFG_V_BITS-1:0]     nom_ff;
   logic signed [B_BITS-1:0]  bup_ff;
   logic signed [B_BITS-1:0]  blo_ff;
   logic [GAIN_BITS-1:0]      gain_ff;
   logic [TC_BITS-1:0]        tr_ff;
   logic [TC_BITS-1:0]        tm_ff;

   // Latched step inputs.
   logic signed [VOLT_BITS-1:0] smp_ff;
   logic [DT_BITS-1:0]          dt_ff;
   logic                        en_ff;

   // Controller state.
   logic signed [VOLT_BITS-1:0] lv_ff;
   logic signed [VOLT_BITS-1:0] lm_ff;
   logic signed [B_BITS-1:0]    lb_ff;
   logic signed [B_BITS-1:0]    app_ind_ff;
   logic signed [B_BITS-1:0]    app_cap_ff;
   logic                        mode_ff;
   logic                        ind_ff;
   logic                        cap_ff;
   logic [TIMER_BITS-1:0]       tmr_ff [3];
   logic                        trip_ff;

   // Intermediate results of the current step.
   logic signed [B_BITS-1:0]    dvp_ff;
   logic signed [B_BITS-1:0]    dv_ff;
   logic signed [VOLT_BITS-1:0] vm_ff;
   logic signed [B_BITS-1:0]    bnew_ff;
   logic [MUL_P_BITS-1:0]       t1_ff;
   logic                        t1neg_ff;
   logic [DIV_N_BITS:0]         num_ff;
   logic                        act_ff;
   logic                        chg_ff;

   // Sequencer.
   state_type state_ff;
   state_type state_in;
   logic      launched_ff;

   // Output register.
   logic                        rsp_valid_ff;
   logic signed [B_BITS-1:0]    rsp_susc_ff;
   logic signed [VOLT_BITS-1:0] rsp_meas_ff;
   logic signed [B_BITS-1:0]    rsp_dev_ff;
   logic                        rsp_ind_ff;
   logic                        rsp_cap_ff;
   logic                        rsp_chg_ff;
   logic                        rsp_trip_ff;

   // Arithmetic unit handshakes.
   logic                    mul_start;
   logic                    mul_done;
   logic [MUL_A_BITS-1:0]   mul_a;
   logic [MUL_B_BITS-1:0]   mul_b;
   logic [MUL_P_BITS-1:0]   mul_p;
   logic                    div_start;
   logic                    div_done;
   logic [DIV_N_BITS-1:0]   div_num;
   logic [DIV_D_BITS-1:0]   div_den;
   logic [DIV_N_BITS-1:0]   div_q;

   // Datapath signals.
   logic [CFG_V_BITS-1:0]       nom_eff;
   logic [TM2_BITS-1:0]         tm2;
   logic [TM2_BITS-1:0]         tr2;
   logic signed [VOLT_BITS-1:0] v_abs;
   logic signed [X_BITS-1:0]    x_s;
   logic [X_BITS-1:0]           x_abs;
   logic signed [VOLT_BITS-1:0] dsel;
   logic signed [DIFF_BITS-1:0] dff_s;
   logic [DIFF_BITS-1:0]        d_abs;
   logic [DIV_N_BITS-1:0]       dev_num;
   logic signed [B_BITS:0]      ssum;
   logic [B_BITS:0]             s_abs;
   logic [TM2_BITS:0]           trd;
   logic [TM2_BITS:0]           trd_abs;
   logic [B_BITS-1:0]           lb_abs;
   logic [TM2_BITS:0]           vden;
   logic [TM2_BITS:0]           bden;
   logic [DIV_N_BITS:0]         num_abs;
   logic [MUL_P_BITS+GAIN_FRAC-1:0] t2_sh;
   logic [DIV_N_BITS:0]         t1s;
   logic [DIV_N_BITS:0]         t2s;
   logic [DIV_N_BITS:0]         num_next;
   logic                        t2neg;
   logic signed [B_BITS-1:0]    bq;
   logic signed [B_BITS-1:0]    bclamp;

   // Update signals.
   logic                        bpos;
   logic                        bchg;
   logic signed [B_BITS:0]      di;
   logic [B_BITS:0]             di_abs;
   logic signed [B_BITS:0]      dc;
   logic [B_BITS:0]             dc_abs;
   logic [B_BITS-1:0]           b_abs;
   logic [B_BITS-1:0]           cap_abs;
   logic                        ind_hit;
   logic                        cap_hit;
   logic                        mode_new;
   logic                        apply_hit;
   logic signed [CMP_BITS-1:0]  vmx;
   logic signed [CMP_BITS-1:0]  nomx;
   logic [2:0]                  over;
   logic [2:0]                  trip_k;
   logic [TIMER_BITS:0]         tsum [3];
   logic [TIMER_BITS-1:0]       tnew [3];
   logic [TIMER_BITS-1:0]       tmr_in [3];
   logic                        trip_any;

   logic req_xfer;
   logic rsp_xfer;
   logic out_free;
   logic csr_xfer;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;

   svcsc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   svcsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .div_num  (div_num),
      .div_den  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   // Operand preparation. Signs are handled here; the units see magnitudes only.
   always_comb begin
      nom_eff = (nom_ff == '0) ? CFG_V_BITS'(1) : nom_ff;
      tm2     = {((tm_ff == '0) ? TC_BITS'(1) : tm_ff), 1'b0};
      tr2     = {((tr_ff == '0) ? TC_BITS'(1) : tr_ff), 1'b0};

      if (smp_ff == VOLT_MIN) begin
         v_abs = VOLT_MAX;
      end else if (smp_ff[VOLT_BITS-1]) begin
         v_abs = -smp_ff;
      end else begin
         v_abs = smp_ff;
      end

      // Numerator of the measurement lag: V + last_voltage - last_measured.
      x_s   = X_BITS'(v_abs) + X_BITS'(lv_ff) - X_BITS'(lm_ff);
      x_abs = x_s[X_BITS-1] ? -x_s : x_s;

      // The deviation divide serves the previous and the new measurement.
      dsel    = (state_ff == ST_DEVP) ? lm_ff : vm_ff;
      dff_s   = DIFF_BITS'(dsel) - DIFF_BITS'($signed({1'b0, ref_ff}));
      d_abs   = dff_s[DIFF_BITS-1] ? -dff_s : dff_s;
      dev_num = DIV_N_BITS'({d_abs, {FRAC_BITS{1'b0}}});

      ssum  = (B_BITS+1)'(dv_ff) + (B_BITS+1)'(dvp_ff);
      s_abs = ssum[B_BITS] ? -ssum : ssum;

      trd     = {1'b0, tr2} - (TM2_BITS+1)'(dt_ff);
      trd_abs = trd[TM2_BITS] ? -trd : trd;
      lb_abs  = lb_ff[B_BITS-1] ? -lb_ff : lb_ff;

      vden = {1'b0, tm2} + (TM2_BITS+1)'(dt_ff);
      bden = {1'b0, tr2} + (TM2_BITS+1)'(dt_ff);

      // Integrator numerator: dt*Kr*(dV+dVprev) + 256*(2Tr-dt)*Bprev.
      t2_sh    = {mul_p, {GAIN_FRAC{1'b0}}};
      t1s      = {2'b00, t1_ff};
      t2s      = {1'b0, t2_sh[DIV_N_BITS-1:0]};
      t2neg    = trd[TM2_BITS] ^ lb_ff[B_BITS-1];
      num_next = (t1neg_ff ? -t1s : t1s) + (t2neg ? -t2s : t2s);
      num_abs  = num_ff[DIV_N_BITS] ? -num_ff : num_ff;

      // Saturate the quotient first; it keeps every comparison with the bounds.
      bq = sat_susc(div_q, num_ff[DIV_N_BITS]);
      if (bq > bup_ff) begin
         bclamp = bup_ff;
      end else if (bq < blo_ff) begin
         bclamp = blo_ff;
      end else begin
         bclamp = bq;
      end
   end

   // Branch update and protection, evaluated with the new susceptance and Vmeas.
   always_comb begin
      bpos    = !bnew_ff[B_BITS-1] && (bnew_ff != '0);
      bchg    = (bnew_ff != lb_ff);
      di      = (B_BITS+1)'(bnew_ff) - (B_BITS+1)'(app_ind_ff);
      di_abs  = di[B_BITS] ? -di : di;
      dc      = (B_BITS+1)'(bnew_ff) - (B_BITS+1)'(app_cap_ff);
      dc_abs  = dc[B_BITS] ? -dc : dc;
      b_abs   = bnew_ff;
      cap_abs = app_cap_ff[B_BITS-1] ? -app_cap_ff : app_cap_ff;
      ind_hit = (PCT_BITS'(di_abs) * PCT_BITS'(CHG_PCT)) > PCT_BITS'(b_abs);
      cap_hit = (app_cap_ff == '0) ||
                ((PCT_BITS'(dc_abs) * PCT_BITS'(CHG_PCT)) > PCT_BITS'(cap_abs));

      if (!bchg) begin
         mode_new  = mode_ff;
         apply_hit = 1'b0;
      end else if (bpos) begin
         mode_new  = ind_hit ? 1'b1 : mode_ff;
         apply_hit = ind_hit;
      end else begin
         mode_new  = cap_hit ? 1'b0 : mode_ff;
         apply_hit = cap_hit;
      end

      vmx  = CMP_BITS'(vm_ff);
      nomx = $signed(CMP_BITS'(nom_eff));
      for (int k = 0; k < 3; k++) begin
         over[k] = (vmx * $signed(CMP_BITS'(PU_SCALE))) >
                   (nomx * $signed(CMP_BITS'(OV_PCT[k])));
         tsum[k] = (TIMER_BITS+1)'(tmr_ff[k]) + (TIMER_BITS+1)'(dt_ff);
         tnew[k] = (tsum[k] > (TIMER_BITS+1)'(TIMER_MAX)) ? TIMER_MAX
                                                          : tsum[k][TIMER_BITS-1:0];
         trip_k[k] = over[k] && (tnew[k] > TRIP_LIMIT[k]);
         tmr_in[k] = over[k] ? tnew[k] : '0;
      end
      trip_any = |trip_k;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) state_in = ST_DEVP;
         end
         ST_DEVP: begin
            if (div_done) state_in = (en_ff && !trip_ff) ? ST_VMUL : ST_WRITE;
         end
         ST_VMUL: begin
            if (mul_done) state_in = ST_VDIV;
         end
         ST_VDIV: begin
            if (div_done) state_in = ST_DEV;
         end
         ST_DEV: begin
            if (div_done) state_in = ST_GAIN;
         end
         ST_GAIN: begin
            if (mul_done) state_in = ST_T1;
         end
         ST_T1: begin
            if (mul_done) state_in = ST_T2;
         end
         ST_T2: begin
            if (mul_done) state_in = ST_BDIV;
         end
         ST_BDIV: begin
            if (div_done) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) state_in = ST_IDLE;
         end
      endcase
   end

   // Unit starts and operand selection. A unit is started once per state.
   always_comb begin
      mul_start = 1'b0;
      div_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      div_num   = '0;
      div_den   = '0;
      unique case (state_ff)
         ST_DEVP, ST_DEV: begin
            div_start = !launched_ff;
            div_num   = dev_num;
            div_den   = DIV_D_BITS'(nom_eff);
         end
         ST_VMUL: begin
            mul_start = !launched_ff;
            mul_a     = MUL_A_BITS'(x_abs[X_BITS-2:0]);
            mul_b     = MUL_B_BITS'(tm2);
         end
         ST_VDIV: begin
            div_start = !launched_ff;
            div_num   = DIV_N_BITS'(mul_p);
            div_den   = DIV_D_BITS'(vden);
         end
         ST_GAIN: begin
            mul_start = !launched_ff;
            mul_a     = MUL_A_BITS'(dt_ff);
            mul_b     = MUL_B_BITS'(gain_ff);
         end
         ST_T1: begin
            mul_start = !launched_ff;
            mul_a     = mul_p[MUL_A_BITS-1:0];
            mul_b     = MUL_B_BITS'(s_abs);
         end
         ST_T2: begin
            mul_start = !launched_ff;
            mul_a     = MUL_A_BITS'(trd_abs[TM2_BITS-1:0]);
            mul_b     = MUL_B_BITS'(lb_abs);
         end
         ST_BDIV: begin
            div_start = !launched_ff;
            div_num   = num_abs[DIV_N_BITS-1:0];
            div_den   = DIV_D_BITS'({bden, {GAIN_FRAC{1'b0}}});
         end
         ST_IDLE, ST_UPDATE, ST_WRITE: begin
            mul_start = 1'b0;
         end
      endcase
   end

   // Control state: sequencer, unit tracking, configuration and controller state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         launched_ff <= 1'b0;
         ref_ff      <= '0;
         nom_ff      <= CFG_V_BITS'(1);
         bup_ff      <= B_BITS'(1) << FRAC_BITS;
         blo_ff      <= -(B_BITS'(1) << FRAC_BITS);
         gain_ff     <= GAIN_BITS'(256);
         tr_ff       <= TC_BITS'(100000);
         tm_ff       <= TC_BITS'(10000);
         lv_ff       <= '0;
         lm_ff       <= '0;
         lb_ff       <= '0;
         app_ind_ff  <= '0;
         app_cap_ff  <= '0;
         mode_ff     <= 1'b0;
         ind_ff      <= 1'b0;
         cap_ff      <= 1'b0;
         trip_ff     <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            tmr_ff[k] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (mul_start || div_start) begin
            launched_ff <= 1'b1;
         end else if (mul_done || div_done) begin
            launched_ff <= 1'b0;
         end

         if (csr_xfer) begin
            unique case (csr_index)
               CSR_REF_VOLTAGE:     ref_ff  <= csr_data[CFG_V_BITS-1:0];
               CSR_NOMINAL_VOLTAGE: nom_ff  <= csr_data[CFG_V_BITS-1:0];
               CSR_B_UPPER:         bup_ff  <= csr_data[B_BITS-1:0];
               CSR_B_LOWER:         blo_ff  <= csr_data[B_BITS-1:0];
               CSR_CTRL_GAIN:       gain_ff <= csr_data[GAIN_BITS-1:0];
               CSR_CTRL_TIME_CONST: tr_ff   <= csr_data[TC_BITS-1:0];
               CSR_MEAS_TIME_CONST: tm_ff   <= csr_data[TC_BITS-1:0];
               default: begin
               end
            endcase
         end

         if (state_ff == ST_UPDATE) begin
            lb_ff <= bnew_ff;
            lv_ff <= v_abs;
            lm_ff <= vm_ff;
            mode_ff <= mode_new;
            if (bchg && bpos && ind_hit) begin
               app_ind_ff <= bnew_ff;
            end
            if (bchg && !bpos && cap_hit) begin
               app_cap_ff <= bnew_ff;
            end
            // A trip opens both switches regardless of the mode.
            if (trip_any) begin
               ind_ff <= 1'b0;
               cap_ff <= 1'b0;
            end else if (bchg) begin
               ind_ff <= mode_new;
               cap_ff <= !mode_new;
            end
            for (int k = 0; k < 3; k++) begin
               tmr_ff[k] <= tmr_in[k];
            end
            trip_ff <= trip_any;
         end

         if (state_ff == ST_WRITE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_xfer) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Step payload and intermediate results.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         smp_ff <= req_voltage_sample;
         dt_ff  <= req_step_time;
         en_ff  <= req_enabled;
         chg_ff <= 1'b0;
      end
      if (state_ff == ST_DEVP && div_done) begin
         dvp_ff <= sat_susc(div_q, dff_s[DIFF_BITS-1]);
         act_ff <= en_ff && !trip_ff;
      end
      if (state_ff == ST_VDIV && div_done) begin
         vm_ff <= sat_volt(div_q, x_s[X_BITS-1]);
      end
      if (state_ff == ST_DEV && div_done) begin
         dv_ff <= sat_susc(div_q, dff_s[DIFF_BITS-1]);
      end
      if (state_ff == ST_T1 && mul_done) begin
         t1_ff    <= mul_p;
         t1neg_ff <= ssum[B_BITS];
      end
      if (state_ff == ST_T2 && mul_done) begin
         num_ff <= num_next;
      end
      if (state_ff == ST_BDIV && div_done) begin
         bnew_ff <= bclamp;
      end
      if (state_ff == ST_UPDATE) begin
         chg_ff <= apply_hit || trip_any;
      end
      if (state_ff == ST_WRITE && out_free) begin
         rsp_susc_ff <= lb_ff;
         rsp_meas_ff <= lm_ff;
         rsp_dev_ff  <= act_ff ? dv_ff : dvp_ff;
         rsp_ind_ff  <= ind_ff;
         rsp_cap_ff  <= cap_ff;
         rsp_chg_ff  <= chg_ff;
         rsp_trip_ff <= trip_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_susceptance       = rsp_susc_ff;
   assign rsp_measured_voltage  = rsp_meas_ff;
   assign rsp_voltage_deviation = rsp_dev_ff;
   assign rsp_inductor_closed   = rsp_ind_ff;
   assign rsp_capacitor_closed  = rsp_cap_ff;
   assign rsp_value_changed     = rsp_chg_ff;
   assign rsp_tripped           = rsp_trip_ff;

endmodule

// ===== hw/rtl/svcsc_mul.sv =====
// Bit-serial unsigned shift-and-add multiplier, one multiplier bit per cycle.
// Depends on svcsc_pkg for its operand widths.
module svcsc_mul (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [svcsc_pkg::MUL_A_BITS-1:0]  mul_a,
   input  logic [svcsc_pkg::MUL_B_BITS-1:0]  mul_b,
   output logic                              done,
   output logic [svcsc_pkg::MUL_P_BITS-1:0]  product
);
   import svcsc_pkg::*;

   localparam int CNT_BITS = $clog2(MUL_B_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(MUL_B_BITS - 1);

   logic [MUL_A_BITS-1:0] a_ff;
   logic [MUL_P_BITS-1:0] p_ff;
   logic [MUL_P_BITS-1:0] p_in;
   logic [MUL_A_BITS:0]   sum;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;

   // The low MUL_B_BITS bits of the product register hold the multiplier bits still to go.
   always_comb begin
      sum  = {1'b0, p_ff[MUL_P_BITS-1:MUL_B_BITS]} + (p_ff[0] ? {1'b0, a_ff} : '0);
      p_in = {sum, p_ff[MUL_B_BITS-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= mul_a;
         p_ff <= {{MUL_A_BITS{1'b0}}, mul_b};
      end else if (busy_ff) begin
         p_ff <= p_in;
      end
   end

   assign done    = done_ff;
   assign product = p_ff;

endmodule

// ===== hw/rtl/svcsc_div.sv =====
// Restoring divider producing one quotient bit per cycle, rounded to nearest.
// Depends on svcsc_pkg for its operand widths.
module svcsc_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [svcsc_pkg::DIV_N_BITS-1:0]  div_num,
   input  logic [svcsc_pkg::DIV_D_BITS-1:0]  div_den,
   output logic                              done,
   output logic [svcsc_pkg::DIV_N_BITS-1:0]  quotient
);
   import svcsc_pkg::*;

   localparam int CNT_BITS = $clog2(DIV_N_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIV_N_BITS - 1);

   logic [DIV_N_BITS-1:0] q_ff;
   logic [DIV_N_BITS-1:0] q_in;
   logic [DIV_D_BITS-1:0] d_ff;
   logic [DIV_D_BITS-1:0] rem_ff;
   logic [DIV_D_BITS-1:0] rem_in;
   logic [DIV_D_BITS:0]   trial;
   logic [DIV_D_BITS:0]   sub;
   logic                  ge;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;

   // The dividend shifts out of the top of q_ff as quotient bits enter below.
   always_comb begin
      trial  = {rem_ff, q_ff[DIV_N_BITS-1]};
      sub    = trial - {1'b0, d_ff};
      ge     = trial >= {1'b0, d_ff};
      rem_in = ge ? sub[DIV_D_BITS-1:0] : trial[DIV_D_BITS-1:0];
      q_in   = {q_ff[DIV_N_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Adding half the divisor up front gives round-half-up on the magnitude.
   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= div_num + DIV_N_BITS'(div_den >> 1);
         d_ff   <= div_den;
         rem_ff <= '0;
      end else if (busy_ff) begin
         q_ff   <= q_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule
